@@ design/wme_pkg.sv @@
// Shared types and constants of the weighted median engine.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package wme_pkg;

  localparam int MAX_SAMPLES = 64;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int SAMPLE_W    = 32;
  localparam int WEIGHT_W    = 32;
  localparam int LIMIT_W     = 40;
  localparam int TOTAL_W     = LIMIT_W + 1;
  localparam int F_W         = TOTAL_W + 2;
  localparam int REM_W       = F_W + 1;
  localparam int BIT_W       = $clog2(SAMPLE_W);
  localparam int IN_W        = SAMPLE_W + WEIGHT_W;
  localparam int OUT_W       = 40;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 1;

  localparam logic [SAMPLE_W-1:0] SIGN_FLIP = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET = {LIMIT_W{1'b1}};

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_INTERPOLATE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_LIMIT = 1'd1;

  typedef struct packed {
    logic load;
    logic pass_start;
    logic scan;
    logic close;
    logic resolve;
    logic div_step;
    logic finish;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found_any;
    logic need_div;
    logic div_last;
  } sts_t;

endpackage

@@ design/wme_ctrl.sv @@
// Sequencer of the weighted median engine: load, scan passes, resolve, divide, output.
// Depends on wme_pkg for the command and status structs.
`timescale 1ns / 1ps

module wme_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  wme_pkg::sts_t sts,
  output wme_pkg::cmd_t cmd
);
  import wme_pkg::*;

  typedef enum logic [2:0] {
    ST_LOAD, ST_PASS, ST_SCAN, ST_CLOSE, ST_RESOLVE, ST_DIV, ST_FIN, ST_OUT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      case (state)
        ST_LOAD:    if (in_valid && in_last) state <= ST_PASS;
        ST_PASS:    state <= ST_SCAN;
        ST_SCAN:    if (sts.scan_done) state <= ST_CLOSE;
        ST_CLOSE:   state <= sts.found_any ? ST_PASS : ST_RESOLVE;
        ST_RESOLVE: state <= sts.need_div ? ST_DIV : ST_OUT;
        ST_DIV:     if (sts.div_last) state <= ST_FIN;
        ST_FIN:     state <= ST_OUT;
        ST_OUT:     if (out_ready) state <= ST_LOAD;
        default:    state <= ST_LOAD;
      endcase
    end
  end

  assign in_ready  = (state == ST_LOAD);
  assign out_valid = (state == ST_OUT);

  always_comb begin
    cmd            = '0;
    cmd.load       = (state == ST_LOAD) && in_valid;
    cmd.pass_start = (state == ST_PASS);
    cmd.scan       = (state == ST_SCAN) && !sts.scan_done;
    cmd.close      = (state == ST_CLOSE);
    cmd.resolve    = (state == ST_RESOLVE);
    cmd.div_step   = (state == ST_DIV);
    cmd.finish     = (state == ST_FIN);
    cmd.clear      = (state == ST_OUT) && out_ready;
  end

endmodule

@@ design/wme_datapath.sv @@
// Datapath of the weighted median engine: sample memory, min-search scan,
// balance tracking, bit-serial multiply-divide and result registers. Uses wme_pkg.
`timescale 1ns / 1ps

module wme_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  wme_pkg::cmd_t                    cmd,
  output wme_pkg::sts_t                    sts,
  input  logic [wme_pkg::SAMPLE_W-1:0]     in_sample,
  input  logic [wme_pkg::WEIGHT_W-1:0]     in_weight,
  input  logic                             cfg_we,
  input  logic [wme_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [wme_pkg::LIMIT_W-1:0]      cfg_value,
  output logic [wme_pkg::SAMPLE_W-1:0]     res_median,
  output logic [wme_pkg::STATUS_W-1:0]     res_status,
  output logic [wme_pkg::CNT_W-1:0]        res_count
);
  import wme_pkg::*;

  // Configuration.
  logic               interp;
  logic [LIMIT_W-1:0] limit;

  // Load bookkeeping.
  logic [CNT_W-1:0]   cnt;
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] total_next;
  logic               ovf;

  // Memory holds {weight, order key}; the key is the sample with its sign bit flipped.
  logic [IN_W-1:0]    mem [MAX_SAMPLES];
  logic [IN_W-1:0]    rd_data;
  logic               rd_v;
  logic [CNT_W-1:0]   addr;

  // Scan for the next larger distinct key.
  logic               first_pass;
  logic [SAMPLE_W-1:0] prev_key;
  logic [SAMPLE_W-1:0] cur_key;
  logic [TOTAL_W-1:0]  cur_sum;
  logic                cur_any;
  logic [SAMPLE_W-1:0] rd_key;
  logic [WEIGHT_W-1:0] rd_w;
  logic                elig;

  // Balance tracking over condensed entries.
  logic [CNT_W-1:0]       ns;
  logic signed [F_W-1:0]  below;
  logic signed [F_W-1:0]  f_cur;
  logic signed [F_W-1:0]  prev_f;
  logic [SAMPLE_W-1:0]    prev_x;
  logic                   found;
  logic                   exact;
  logic                   rankb_odd;
  logic [SAMPLE_W-1:0]    xa;
  logic [SAMPLE_W-1:0]    xb;
  logic signed [F_W-1:0]  fa;
  logic signed [F_W-1:0]  fb;

  // Divider.
  logic [REM_W-1:0]    rem;
  logic [REM_W-1:0]    den;
  logic [REM_W-1:0]    dvd_a;
  logic [SAMPLE_W-1:0] dval;
  logic [SAMPLE_W-1:0] quo;
  logic [BIT_W-1:0]    bitn;
  logic                phase;
  logic [REM_W-1:0]    rem_sh;
  logic [REM_W-1:0]    rem_add;
  logic [SAMPLE_W-1:0] quo_fix;

  logic [STATUS_W-1:0] status_c;
  logic signed [F_W-1:0] neg_fa;
  logic [SAMPLE_W-1:0] pick_key;

  always_ff @(posedge clk) begin
    if (rst) begin
      interp <= 1'b0;
      limit  <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_INTERPOLATE:  interp <= cfg_value[0];
        CFG_WEIGHT_LIMIT: limit  <= cfg_value;
        default:          ;
      endcase
    end
  end

  assign total_next = total + TOTAL_W'(in_weight);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      cnt   <= '0;
      total <= '0;
      ovf   <= 1'b0;
    end else if (cmd.load && (cnt < CNT_W'(MAX_SAMPLES))) begin
      cnt <= cnt + 1'b1;
      if (!ovf) begin
        total <= total_next;
        if (total_next > TOTAL_W'(limit)) ovf <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && (cnt < CNT_W'(MAX_SAMPLES))) begin
      mem[cnt[ADDR_W-1:0]] <= {in_weight, in_sample ^ SIGN_FLIP};
    end
    if (cmd.scan && (addr < cnt)) begin
      rd_data <= mem[addr[ADDR_W-1:0]];
    end
  end

  assign rd_key = rd_data[SAMPLE_W-1:0];
  assign rd_w   = rd_data[IN_W-1:SAMPLE_W];
  assign elig   = (rd_w != '0) && (first_pass || (rd_key > prev_key));

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v    <= 1'b0;
      addr    <= '0;
      cur_any <= 1'b0;
    end else if (cmd.pass_start) begin
      rd_v    <= 1'b0;
      addr    <= '0;
      cur_any <= 1'b0;
    end else if (cmd.scan) begin
      rd_v <= (addr < cnt);
      if (addr < cnt) addr <= addr + 1'b1;
      if (rd_v && elig) begin
        if (!cur_any || (rd_key < cur_key)) begin
          cur_key <= rd_key;
          cur_sum <= TOTAL_W'(rd_w);
          cur_any <= 1'b1;
        end else if (rd_key == cur_key) begin
          cur_sum <= cur_sum + TOTAL_W'(rd_w);
        end
      end
    end
  end

  assign f_cur = (below <<< 1) + F_W'(cur_sum) - F_W'(total);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      ns         <= '0;
      below      <= '0;
      found      <= 1'b0;
      exact      <= 1'b0;
      first_pass <= 1'b1;
    end else if (cmd.close && cur_any) begin
      ns         <= ns + 1'b1;
      first_pass <= 1'b0;
      prev_key   <= cur_key;
      below      <= below + F_W'(cur_sum);
      prev_x     <= cur_key;
      prev_f     <= f_cur;
      if (!found && (f_cur >= 0)) begin
        found     <= 1'b1;
        xb        <= cur_key;
        fb        <= f_cur;
        rankb_odd <= ns[0];
        if (f_cur == 0) begin
          exact <= 1'b1;
          xa    <= cur_key;
          fa    <= '0;
        end else begin
          xa <= prev_x;
          fa <= prev_f;
        end
      end
    end
  end

  always_comb begin
    if (ovf) status_c = STATUS_OVERFLOW;
    else if (ns == '0) status_c = STATUS_EMPTY;
    else status_c = STATUS_OK;
  end

  assign neg_fa = -fa;

  // Nearer bracketing sample; a tie goes to the even condensed rank.
  always_comb begin
    if (exact) pick_key = xb;
    else if (neg_fa < fb) pick_key = xa;
    else if (neg_fa > fb) pick_key = xb;
    else pick_key = rankb_odd ? xa : xb;
  end

  assign sts.scan_done = (addr == cnt) && !rd_v;
  assign sts.found_any = cur_any;
  assign sts.need_div  = (status_c == STATUS_OK) && !exact && interp;
  assign sts.div_last  = phase && (bitn == '0);

  assign rem_sh  = {rem[REM_W-2:0], 1'b0};
  assign rem_add = rem + dvd_a;
  assign quo_fix = (quo == '0) ? SAMPLE_W'(1) : quo;

  // floor(fb * (xb - xa) / (fb - fa)), one multiplier bit per shift phase and add phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
      bitn  <= '0;
    end else if (cmd.resolve) begin
      phase <= 1'b0;
      bitn  <= BIT_W'(SAMPLE_W - 1);
      rem   <= '0;
      quo   <= '0;
      dval  <= xb - xa;
      dvd_a <= REM_W'(fb);
      den   <= REM_W'(fb - fa);
    end else if (cmd.div_step) begin
      if (!phase) begin
        if (rem_sh >= den) begin
          rem <= rem_sh - den;
          quo <= {quo[SAMPLE_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[SAMPLE_W-2:0], 1'b0};
        end
        phase <= 1'b1;
      end else begin
        if (dval[bitn]) begin
          if (rem_add >= den) begin
            rem <= rem_add - den;
            quo <= quo + 1'b1;
          end else begin
            rem <= rem_add;
          end
        end
        phase <= 1'b0;
        bitn  <= bitn - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resolve) begin
      res_status <= status_c;
      res_count  <= ns;
      res_median <= (status_c == STATUS_OK) ? (pick_key ^ SIGN_FLIP) : '0;
    end else if (cmd.finish) begin
      res_median <= (xb - quo_fix) ^ SIGN_FLIP;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_SAMPLES))
    else $error("item count beyond capacity");

  a_clear_count: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> (cnt == '0) && (ns == '0) && !ovf)
    else $error("set state not cleared after result");

  a_read_follows_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(rd_v) |-> $past(cmd.scan))
    else $error("read data valid without a scan cycle");

  // Once the total has overflowed it stops growing, so the balances no longer bracket.
  a_found_bracket: assert property (@(posedge clk) disable iff (rst)
    (found && !exact && !ovf) |-> (fb > 0) && (fa < 0))
    else $error("bracketing balances of wrong sign");

endmodule

@@ design/weighted_median_engine_top.sv @@
// Top level of the weighted median engine.
// Joins wme_ctrl and wme_datapath; depends on wme_pkg.
//
// Input stream: one (sample, weight) pair per transfer, tlast marks the end of
// the set. Up to 64 pairs are stored; later pairs of the same set are dropped,
// but their tlast still closes the set. Loading takes one cycle per pair.
// After the closing transfer the engine walks its sample memory once per
// distinct nonzero-weight sample plus once more, so D+1 passes for D distinct
// samples. With interpolation, for a set with status OK whose median does not
// fall exactly on a sample, a bit-serial multiply-divide follows. Then one
// result is shown on the output stream and held until the receiver takes it;
// no input is accepted while a set is in process or its result waits.
// Configuration writes (index 0 interpolate, index 1 weight limit) are taken
// in any cycle and belong between sets. Reset is synchronous: it empties the
// current set, drops any pending result and restores the register defaults.
`timescale 1ns / 1ps

module weighted_median_engine_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // sample [31:0], weight [63:32]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // median [31:0], distinct_count [38:32], zero [39]
  output logic [1:0]  m_axis_tuser,   // status [1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [39:0] cfg_data
);
  import wme_pkg::*;

  cmd_t                cmd;
  sts_t                sts;
  logic [SAMPLE_W-1:0] res_median;
  logic [STATUS_W-1:0] res_status;
  logic [CNT_W-1:0]    res_count;

  assign cfg_ready = 1'b1;

  wme_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_last   (s_axis_tlast),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wme_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_sample  (s_axis_tdata[SAMPLE_W-1:0]),
    .in_weight  (s_axis_tdata[IN_W-1:SAMPLE_W]),
    .cfg_we     (cfg_valid),
    .cfg_idx    (cfg_index),
    .cfg_value  (cfg_data),
    .res_median (res_median),
    .res_status (res_status),
    .res_count  (res_count)
  );

  assign m_axis_tdata = {1'b0, res_count, res_median};
  assign m_axis_tuser = res_status;

endmodule
